/* hw/rtl/cva_pkg.sv */
`default_nettype none

package cva_pkg;

	// data path widths
	localparam int unsigned VEC_W = 32;
	localparam int unsigned ANG_W = 11;
	localparam int unsigned ANGLE_OUT_W = 10;
	localparam int unsigned LEN_OUT_W = 12;
	localparam int unsigned GAIN_W = 20;
	localparam int unsigned LEN_SHIFT = 20;
	localparam int unsigned MAX_STEPS = 7;

	// angle accumulator start, 512 units per turn
	localparam logic signed [ANG_W-1:0] ANGLE_START_NEG = 11'sd384;
	localparam logic signed [ANG_W-1:0] ANGLE_START_POS = 11'sd128;

	// length gain
	localparam logic [GAIN_W-1:0] LEN_GAIN = 20'h9B74E;

	typedef struct packed {
		logic signed [VEC_W-1:0] vec_x;
		logic signed [VEC_W-1:0] vec_y;
	} cva_in_t;

	typedef struct packed {
		logic signed [ANGLE_OUT_W-1:0] angle_out;
		logic signed [LEN_OUT_W-1:0] proj_length;
	} cva_out_t;

	// working vector and angle between stages
	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] ang;
	} cva_stage_t;

	// arctangent step for each shift
	function automatic logic signed [ANG_W-1:0] step_angle(input int unsigned idx);
		logic signed [ANG_W-1:0] a;
		case (idx)
			0: a = 11'sd64;
			1: a = 11'sd37;
			2: a = 11'sd19;
			3: a = 11'sd10;
			4: a = 11'sd5;
			5: a = 11'sd2;
			default: a = 11'sd1;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/cva_prep.sv */
`default_nettype none

module cva_prep
	import cva_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cva_in_t    d_in,
	input  wire logic       valid_in,
	output logic            stall_up,
	output cva_stage_t      d_s1,
	output logic            valid_s1,
	input  wire logic       stall_dn
);

	cva_stage_t nxt;

	// fold left half plane into right half, start angle accordingly
	always_comb begin
		if (d_in.vec_x[VEC_W-1]) begin
			nxt.x = -d_in.vec_x;
			nxt.y = -d_in.vec_y;
			nxt.ang = ANGLE_START_NEG;
		end else begin
			nxt.x = d_in.vec_x;
			nxt.y = d_in.vec_y;
			nxt.ang = ANGLE_START_POS;
		end
	end

	// register holds while full and downstream stalls
	assign stall_up = valid_s1 && stall_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_up) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_up && valid_in) begin
			d_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/cva_step.sv */
`default_nettype none

module cva_step
	import cva_pkg::*;
#(
	parameter int unsigned SHIFT = 0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cva_stage_t d_in,
	input  wire logic       valid_in,
	output logic            stall_up,
	output cva_stage_t      d_s1,
	output logic            valid_s1,
	input  wire logic       stall_dn
);

	localparam logic signed [ANG_W-1:0] STEP = step_angle(SHIFT);

	logic signed [VEC_W-1:0] xi;
	logic signed [VEC_W-1:0] yi;
	logic signed [VEC_W-1:0] sx;
	logic signed [VEC_W-1:0] sy;
	cva_stage_t nxt;

	assign xi = d_in.x;
	assign yi = d_in.y;
	assign sx = xi >>> SHIFT;
	assign sy = yi >>> SHIFT;

	// one vectoring rotation, direction from the sign of y
	always_comb begin
		if (yi[VEC_W-1]) begin
			nxt.y = yi + sx;
			nxt.x = xi - sy;
			nxt.ang = d_in.ang - STEP;
		end else begin
			nxt.y = yi - sx;
			nxt.x = xi + sy;
			nxt.ang = d_in.ang + STEP;
		end
	end

	assign stall_up = valid_s1 && stall_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_up) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_up && valid_in) begin
			d_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/cva_len.sv */
`default_nettype none

module cva_len
	import cva_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cva_stage_t d_in,
	input  wire logic       valid_in,
	output logic            stall_up,
	output cva_out_t        d_s1,
	output logic            valid_s1,
	input  wire logic       stall_dn
);

	logic [VEC_W-1:0] prod;
	cva_out_t nxt;

	// low word of x times gain, then take the bits above the shift
	assign prod = VEC_W'(d_in.x * {{(VEC_W-GAIN_W){1'b0}}, LEN_GAIN});

	always_comb begin
		nxt.angle_out = d_in.ang[ANG_W-1:1];
		nxt.proj_length = prod[LEN_SHIFT+LEN_OUT_W-1:LEN_SHIFT];
	end

	assign stall_up = valid_s1 && stall_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_up) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_up && valid_in) begin
			d_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/cordic_vector_angle_unit.sv */
// cordic vector angle unit
// input channel: vec_valid / vec_stall carry one item, a signed 32-bit vector
// (vec_x, vec_y). the item is taken at a rising edge with vec_valid high and
// vec_stall low.
// output channel: res_valid / res_stall carry one result item per input
// item, the angle in 256 units per turn and the gain-scaled length.
// pipeline: the accepting edge loads the fold stage, the item then moves
// through the cordic rotation stages in order, and at last it loads the
// multiply stage that is also the output register, STEPS + 2 register
// stages in all. throughput: one item per cycle while the receiver does
// not stall; every stage has its own valid bit.
// when the receiver stalls, the output register holds its item and the
// stages behind it keep filling any empty slots, so new items are still
// taken until the whole pipeline is full.
// reset clears all valid bits; no result is pending after reset.
`default_nettype none

module cordic_vector_angle_unit
	import cva_pkg::*;
#(
	parameter int unsigned STEPS = MAX_STEPS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cva_in_t  vec,
	input  wire logic     vec_valid,
	output logic          vec_stall,
	output cva_out_t      res,
	output logic          res_valid,
	input  wire logic     res_stall
);

	localparam int unsigned DEPTH = STEPS + 2;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cva_stage_t st_d [STEPS+1];
	logic st_v [STEPS+1];
	logic st_stall [STEPS+1];

	// fold stage
	cva_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.d_in     (vec),
		.valid_in (vec_valid),
		.stall_up (vec_stall),
		.d_s1     (st_d[0]),
		.valid_s1 (st_v[0]),
		.stall_dn (st_stall[0])
	);

	// rotation stages
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		cva_step #(
			.SHIFT (i)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.d_in     (st_d[i]),
			.valid_in (st_v[i]),
			.stall_up (st_stall[i]),
			.d_s1     (st_d[i+1]),
			.valid_s1 (st_v[i+1]),
			.stall_dn (st_stall[i+1])
		);
	end

	// length multiply and output register
	cva_len u_len (
		.clk      (clk),
		.arst_n   (arst_n),
		.d_in     (st_d[STEPS]),
		.valid_in (st_v[STEPS]),
		.stall_up (st_stall[STEPS]),
		.d_s1     (res),
		.valid_s1 (res_valid),
		.stall_dn (res_stall)
	);

	// occupancy tracking for checks
	logic [DEPTH-1:0] vld;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		for (int i = 0; i <= STEPS; i++) begin
			vld[i] = st_v[i];
		end
		vld[DEPTH-1] = res_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({vec_valid && !vec_stall, res_valid && !res_stall})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// items in flight match the stage valid bits
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == 32'($countones(vld)))
		else $error("pipeline occupancy mismatch");

	// a free receiver never backs up the input side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_stall |-> !vec_stall)
		else $error("input stalled while output drains");

	// angle result stays in its reachable range
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.angle_out >= -10'sd5 && res.angle_out <= 10'sd261))
		else $error("angle out of range");

	// a full pipeline under stall refuses input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cnt_q) == DEPTH && res_stall) |-> vec_stall)
		else $error("input taken while pipeline full");

endmodule

`default_nettype wire
